FILE: rtl/core/metf_pkg.sv
package metf_pkg;

    localparam int unsigned ACTION_W     = 2;
    localparam int unsigned CAN_ID_W     = 11;
    localparam int unsigned MOTOR_W      = 4;
    localparam int unsigned SLOT_W       = 4;
    localparam int unsigned IDX_MAX_W    = 3;
    localparam int unsigned GEAR_MASK_W  = 16;
    localparam int unsigned ANGLE_W      = 16;
    localparam int unsigned TURNS_W      = 16;
    localparam int unsigned WORD_W       = 16;
    localparam int unsigned SHAFT_W      = 29;
    localparam int unsigned COUNT_SHIFT  = 13;
    localparam int unsigned X_W          = 30;
    localparam int unsigned MAG_W        = 29;
    localparam int unsigned MAG_SPLIT    = 15;
    localparam int unsigned RECIP_W      = 36;
    localparam int unsigned RECIP_SHIFT  = 36;
    localparam int unsigned PP_LO_W      = MAG_SPLIT + RECIP_W;
    localparam int unsigned PP_HI_W      = MAG_W - MAG_SPLIT + RECIP_W;
    localparam int unsigned SUM_W        = MAG_W + RECIP_W + 1;

    localparam logic [CAN_ID_W-1:0]     BASE_ID        = 11'h201;
    localparam logic signed [ANGLE_W:0] JUMP_LIMIT     = 17'sd4096;
    localparam logic signed [ANGLE_W:0] JUMP_LIMIT_NEG = -17'sd4096;
    localparam logic signed [TURNS_W-1:0] TURNS_MAX    = 16'sh7FFF;
    localparam logic signed [TURNS_W-1:0] TURNS_MIN    = 16'sh8000;

    // ceil(45 * 2^36 / (4 * gear)), exact quotient for magnitudes below 2^29
    localparam logic [RECIP_W-1:0] RECIP_GEAR_LOW  = 36'd40689163857;
    localparam logic [RECIP_W-1:0] RECIP_GEAR_HIGH = 36'd21474836480;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FEEDBACK = 2'd0,
        ACT_REGISTER = 2'd1,
        ACT_CLEAR    = 2'd2
    } metf_action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                bus;
        logic [CAN_ID_W-1:0] can_id;
        logic [MOTOR_W-1:0]  motor_number;
        logic [7:0]          angle_high;
        logic [7:0]          angle_low;
        logic [7:0]          speed_high;
        logic [7:0]          speed_low;
        logic [7:0]          current_high;
        logic [7:0]          current_low;
    } metf_item_t;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_W-1:0]         slot;
        logic signed [TURNS_W-1:0] turns;
        logic signed [WORD_W-1:0]  speed;
        logic signed [WORD_W-1:0]  current;
    } metf_info_t;

    typedef struct packed {
        metf_info_t            info;
        logic signed [X_W-1:0] x;
    } metf_track_t;

endpackage

FILE: rtl/core/metf_if.sv
interface metf_frame_if;
    import metf_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                bus;
    logic [CAN_ID_W-1:0] can_id;
    logic [MOTOR_W-1:0]  motor_number;
    logic [7:0]          angle_high;
    logic [7:0]          angle_low;
    logic [7:0]          speed_high;
    logic [7:0]          speed_low;
    logic [7:0]          current_high;
    logic [7:0]          current_low;

    modport source
    (
        output valid, action, bus, can_id, motor_number, angle_high, angle_low,
               speed_high, speed_low, current_high, current_low,
        input  ready
    );

    modport sink
    (
        input  valid, action, bus, can_id, motor_number, angle_high, angle_low,
               speed_high, speed_low, current_high, current_low,
        output ready
    );
endinterface

interface metf_report_if;
    import metf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [SLOT_W-1:0]         slot;
    logic signed [TURNS_W-1:0] turns;
    logic signed [SHAFT_W-1:0] shaft_angle_q8;
    logic signed [WORD_W-1:0]  speed;
    logic signed [WORD_W-1:0]  current;

    modport source
    (
        output valid, hit, slot, turns, shaft_angle_q8, speed, current,
        input  ready
    );

    modport sink
    (
        input  valid, hit, slot, turns, shaft_angle_q8, speed, current,
        output ready
    );
endinterface

FILE: rtl/core/metf_slot_bank.sv
module metf_slot_bank #(
    parameter int BUSES         = 2,
    parameter int SLOTS_PER_BUS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  metf_pkg::metf_item_t  item,
    input  logic                  apply,
    output metf_pkg::metf_track_t track
);
    import metf_pkg::*;

    localparam int NUM_SLOTS = BUSES * SLOTS_PER_BUS;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_SLOTS-1:0]      registered_reg;
    logic [ANGLE_W-1:0]        prev_angle_reg [NUM_SLOTS];
    logic signed [TURNS_W-1:0] turn_count_reg [NUM_SLOTS];
    logic [ANGLE_W-1:0]        angle_offset_reg [NUM_SLOTS];

    logic                      registered_next;
    logic [ANGLE_W-1:0]        prev_angle_next;
    logic signed [TURNS_W-1:0] turn_count_next;
    logic [ANGLE_W-1:0]        angle_offset_next;

    logic                      bus_ok;
    logic                      id_ok;
    logic                      num_ok;
    logic                      addr_ok;
    logic                      slot_hit;
    logic [CAN_ID_W-1:0]       id_off;
    logic [MOTOR_W-1:0]        num_off;
    logic [IDX_MAX_W-1:0]      idx;
    logic [SLOT_W-1:0]         slot;
    logic [IDX_W-1:0]          sel;
    logic                      registered_cur;
    logic [ANGLE_W-1:0]        last_cur;
    logic signed [TURNS_W-1:0] turns_cur;
    logic [ANGLE_W-1:0]        offset_cur;
    logic [ANGLE_W-1:0]        angle;
    logic signed [ANGLE_W:0]   delta;
    logic signed [WORD_W-1:0]  speed;
    logic signed [WORD_W-1:0]  current;
    logic signed [X_W-1:0]     x;

    assign angle   = {item.angle_high, item.angle_low};
    assign bus_ok  = int'(item.bus) < BUSES;
    assign id_off  = item.can_id - BASE_ID;
    assign id_ok   = (item.can_id >= BASE_ID) && (id_off < CAN_ID_W'(SLOTS_PER_BUS));
    assign num_off = item.motor_number - MOTOR_W'(1);
    assign num_ok  = (item.motor_number != '0)
                  && (item.motor_number <= MOTOR_W'(SLOTS_PER_BUS));

    always_comb
    begin
        case (metf_action_t'(item.action))
            ACT_FEEDBACK:
            begin
                addr_ok = bus_ok && id_ok;
                idx     = id_off[IDX_MAX_W-1:0];
            end
            ACT_REGISTER, ACT_CLEAR:
            begin
                addr_ok = bus_ok && num_ok;
                idx     = num_off[IDX_MAX_W-1:0];
            end
            default:
            begin
                addr_ok = 1'b0;
                idx     = '0;
            end
        endcase
    end

    assign slot = SLOT_W'(item.bus) * SLOT_W'(SLOTS_PER_BUS) + SLOT_W'(idx);
    assign sel  = addr_ok ? IDX_W'(slot) : '0;

    assign registered_cur = registered_reg[sel];
    assign last_cur       = prev_angle_reg[sel];
    assign turns_cur      = turn_count_reg[sel];
    assign offset_cur     = angle_offset_reg[sel];

    assign delta = $signed({1'b0, angle}) - $signed({1'b0, last_cur});

    always_comb
    begin
        registered_next   = registered_cur;
        prev_angle_next   = last_cur;
        turn_count_next   = turns_cur;
        angle_offset_next = offset_cur;
        slot_hit          = 1'b0;
        speed             = '0;
        current           = '0;
        case (metf_action_t'(item.action))
            ACT_FEEDBACK:
            begin
                if (addr_ok && registered_cur)
                begin
                    slot_hit        = 1'b1;
                    prev_angle_next = angle;
                    speed           = $signed({item.speed_high, item.speed_low});
                    current         = $signed({item.current_high, item.current_low});
                    if (delta > JUMP_LIMIT)
                    begin
                        if (turns_cur != TURNS_MIN)
                            turn_count_next = turns_cur - 16'sd1;
                    end
                    else if (delta < JUMP_LIMIT_NEG)
                    begin
                        if (turns_cur != TURNS_MAX)
                            turn_count_next = turns_cur + 16'sd1;
                    end
                end
            end
            ACT_REGISTER:
            begin
                if (addr_ok)
                begin
                    slot_hit          = 1'b1;
                    registered_next   = 1'b1;
                    turn_count_next   = '0;
                    angle_offset_next = last_cur;
                end
            end
            ACT_CLEAR:
            begin
                if (addr_ok && registered_cur)
                begin
                    slot_hit        = 1'b1;
                    turn_count_next = '0;
                end
            end
            default:
            begin
                slot_hit = 1'b0;
            end
        endcase
    end

    assign x = X_W'($signed({turn_count_next, {COUNT_SHIFT{1'b0}}}))
             + X_W'($signed({1'b0, prev_angle_next}))
             - X_W'($signed({1'b0, angle_offset_next}));

    always_comb
    begin
        track.info.hit     = slot_hit;
        track.info.slot    = slot_hit ? slot : '0;
        track.info.turns   = slot_hit ? turn_count_next : '0;
        track.info.speed   = speed;
        track.info.current = current;
        track.x            = slot_hit ? x : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            registered_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                prev_angle_reg[i]   <= '0;
                turn_count_reg[i]   <= '0;
                angle_offset_reg[i] <= '0;
            end
        end
        else if (apply && slot_hit)
        begin
            registered_reg[sel]   <= registered_next;
            prev_angle_reg[sel]   <= prev_angle_next;
            turn_count_reg[sel]   <= turn_count_next;
            angle_offset_reg[sel] <= angle_offset_next;
        end
    end

endmodule

FILE: rtl/core/multiturn_encoder_feedback_tracker_top.sv
// Multi-turn encoder tracker. Takes one beat per clock on frame while the pipeline
// is not backed up by a report stall, and returns one report beat per frame beat,
// in order. The first stage after the input register reads and updates the
// addressed slot in flip-flops, so back-to-back beats to the same slot need no
// forwarding; the following three stages take the magnitude of the unwrapped
// count, multiply it by the gear reciprocal as two partial products, and
// recombine and sign the shaft angle. A stall on report backs up stage by stage,
// and frame stays ready while any stage has room. The gear mask is written
// through cfg_we / cfg_wdata; the user must write it only while idle, as the
// block itself does not enforce this.
module multiturn_encoder_feedback_tracker_top #(
    parameter int BUSES         = 2,
    parameter int SLOTS_PER_BUS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [metf_pkg::GEAR_MASK_W-1:0] cfg_wdata,
    metf_frame_if.sink                       frame,
    metf_report_if.source                    report
);
    import metf_pkg::*;

    logic [GEAR_MASK_W-1:0] gear_mask_reg;

    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic adv0;
    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;

    metf_item_t            s0_item_reg;
    metf_track_t           s1_track_next;
    metf_track_t           s1_track_reg;
    metf_info_t            s2_info_reg;
    logic                  s2_neg_reg;
    logic                  s2_neg_next;
    logic [MAG_W-1:0]      s2_mag_reg;
    logic [MAG_W-1:0]      s2_mag_next;
    logic                  s2_gear_high_reg;
    metf_info_t            s3_info_reg;
    logic                  s3_neg_reg;
    logic [PP_LO_W-1:0]    s3_pp_lo_reg;
    logic [PP_LO_W-1:0]    s3_pp_lo_next;
    logic [PP_HI_W-1:0]    s3_pp_hi_reg;
    logic [PP_HI_W-1:0]    s3_pp_hi_next;
    logic [RECIP_W-1:0]    recip;
    metf_info_t            out_info_reg;
    logic signed [SHAFT_W-1:0] out_shaft_reg;
    logic signed [SHAFT_W-1:0] out_shaft_next;
    logic [SUM_W-1:0]      sum;
    logic [MAG_W-1:0]      quot;
    metf_item_t            frame_item;

    assign adv4 = !out_valid_reg || report.ready;
    assign adv3 = !s3_valid_reg || adv4;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign adv0 = !s0_valid_reg || adv1;
    assign frame.ready = adv0;

    always_comb
    begin
        frame_item.action       = frame.action;
        frame_item.bus          = frame.bus;
        frame_item.can_id       = frame.can_id;
        frame_item.motor_number = frame.motor_number;
        frame_item.angle_high   = frame.angle_high;
        frame_item.angle_low    = frame.angle_low;
        frame_item.speed_high   = frame.speed_high;
        frame_item.speed_low    = frame.speed_low;
        frame_item.current_high = frame.current_high;
        frame_item.current_low  = frame.current_low;
    end

    metf_slot_bank #(
        .BUSES         (BUSES),
        .SLOTS_PER_BUS (SLOTS_PER_BUS)
    ) u_slot_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s0_item_reg),
        .apply (s0_valid_reg && adv1),
        .track (s1_track_next)
    );

    assign s2_neg_next = s1_track_reg.x < 0;
    assign s2_mag_next = s2_neg_next ? MAG_W'(-s1_track_reg.x) : MAG_W'(s1_track_reg.x);

    assign recip         = s2_gear_high_reg ? RECIP_GEAR_HIGH : RECIP_GEAR_LOW;
    assign s3_pp_lo_next = PP_LO_W'(s2_mag_reg[MAG_SPLIT-1:0]) * PP_LO_W'(recip);
    assign s3_pp_hi_next = PP_HI_W'(s2_mag_reg[MAG_W-1:MAG_SPLIT]) * PP_HI_W'(recip);

    assign sum  = (SUM_W'(s3_pp_hi_reg) << MAG_SPLIT) + SUM_W'(s3_pp_lo_reg);
    assign quot = sum[RECIP_SHIFT +: MAG_W];
    assign out_shaft_next = s3_neg_reg ? $signed(-quot) : $signed(quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            gear_mask_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
                s0_valid_reg <= frame.valid;
            if (adv1)
                s1_valid_reg <= s0_valid_reg;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
            if (adv4)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // payload: advance only with a beat behind it
    always_ff @(posedge clk)
    begin
        if (adv0 && frame.valid)
            s0_item_reg <= frame_item;
        if (adv1 && s0_valid_reg)
            s1_track_reg <= s1_track_next;
        if (adv2 && s1_valid_reg)
        begin
            s2_info_reg      <= s1_track_reg.info;
            s2_neg_reg       <= s2_neg_next;
            s2_mag_reg       <= s2_mag_next;
            s2_gear_high_reg <= gear_mask_reg[s1_track_reg.info.slot];
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_info_reg  <= s2_info_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_pp_lo_reg <= s3_pp_lo_next;
            s3_pp_hi_reg <= s3_pp_hi_next;
        end
        if (adv4 && s3_valid_reg)
        begin
            out_info_reg  <= s3_info_reg;
            out_shaft_reg <= out_shaft_next;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.hit            = out_info_reg.hit;
    assign report.slot           = out_info_reg.slot;
    assign report.turns          = out_info_reg.turns;
    assign report.shaft_angle_q8 = out_shaft_reg;
    assign report.speed          = out_info_reg.speed;
    assign report.current        = out_info_reg.current;

    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && !report.hit |->
            report.slot == '0 && report.turns == '0 && report.shaft_angle_q8 == '0
            && report.speed == '0 && report.current == '0)
        else $error("miss beat carries non-zero fields");

    a_miss_no_count : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_track_reg.info.hit |-> s1_track_reg.x == '0)
        else $error("miss beat carries an unwrapped count");

    a_neg_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_neg_reg |-> s2_mag_reg != '0)
        else $error("negative count with zero magnitude");

    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg
            && !report.ready |-> !frame.ready)
        else $error("frame ready while every stage is held");

endmodule

FILE: test/tb_multiturn_encoder_feedback_tracker_top.sv
module tb_multiturn_encoder_feedback_tracker_top;
    import metf_pkg::*;

    localparam int BUSES            = 2;
    localparam int SLOTS_PER_BUS    = 8;
    localparam int SLOT_COUNT       = BUSES * SLOTS_PER_BUS;
    localparam int COUNTS_PER_TURN  = 8192;
    localparam int GEAR_LOW         = 19;
    localparam int GEAR_HIGH        = 36;
    localparam int RANDOM_PER_PHASE = 210;
    localparam int TURN_RUN         = 40;
    localparam int DRAIN_CYCLES     = 8;
    localparam int STALL_LIMIT      = 4000;
    localparam int CALM_PERIOD      = 3000;
    localparam int CALM_SPAN        = 600;
    localparam int IDLE_PERCENT     = 12;
    localparam logic [ANGLE_W-1:0]  RUN_BASE = 16'h2000;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_W-1:0]         slot;
        logic signed [TURNS_W-1:0] turns;
        logic signed [SHAFT_W-1:0] shaft_angle_q8;
        logic signed [WORD_W-1:0]  speed;
        logic signed [WORD_W-1:0]  current;
    } tracker_report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [GEAR_MASK_W-1:0] cfg_wdata;

    metf_frame_if  frame_bus ();
    metf_report_if report_bus ();

    multiturn_encoder_feedback_tracker_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .frame     (frame_bus.sink),
        .report    (report_bus.source)
    );

    logic [GEAR_MASK_W-1:0]    gear_mask;
    logic                      slot_live [SLOT_COUNT];
    logic [ANGLE_W-1:0]        prev_angle [SLOT_COUNT];
    logic signed [TURNS_W-1:0] turn_count [SLOT_COUNT];
    logic [ANGLE_W-1:0]        angle_offset [SLOT_COUNT];
    logic [ANGLE_W-1:0]        walk_angle [SLOT_COUNT];

    metf_item_t      pending_frames [$];
    tracker_report_t reports_due [$];

    int unsigned n_queued;
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_errors;
    int unsigned tick;
    int unsigned quiet_cycles;
    logic        beat_in;
    logic        calm;

    assign calm = (tick % CALM_PERIOD) < CALM_SPAN;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic tracker_report_t track_frame(metf_item_t it);
        tracker_report_t r;
        int idx;
        int s;
        int d;
        logic [ANGLE_W-1:0] a;
        longint x;
        longint gear;
        longint q;
        r = '{default: '0};
        idx = -1;
        if (it.action == ACT_FEEDBACK)
            idx = int'(it.can_id) - int'(BASE_ID);
        else if (it.action == ACT_REGISTER || it.action == ACT_CLEAR)
            idx = int'(it.motor_number) - 1;
        if (idx < 0 || idx >= SLOTS_PER_BUS)
            return r;
        s = int'(it.bus) * SLOTS_PER_BUS + idx;
        if (it.action == ACT_REGISTER)
        begin
            slot_live[s] = 1'b1;
            turn_count[s] = '0;
            angle_offset[s] = prev_angle[s];
        end
        else
        begin
            if (!slot_live[s])
                return r;
            if (it.action == ACT_CLEAR)
                turn_count[s] = '0;
            else
            begin
                a = {it.angle_high, it.angle_low};
                d = int'(a) - int'(prev_angle[s]);
                prev_angle[s] = a;
                if (d > JUMP_LIMIT && turn_count[s] != TURNS_MIN)
                    turn_count[s] = turn_count[s] - 16'sd1;
                else if (d < JUMP_LIMIT_NEG && turn_count[s] != TURNS_MAX)
                    turn_count[s] = turn_count[s] + 16'sd1;
                r.speed = {it.speed_high, it.speed_low};
                r.current = {it.current_high, it.current_low};
            end
        end
        x = longint'(turn_count[s]) * COUNTS_PER_TURN
          + longint'(prev_angle[s]) - longint'(angle_offset[s]);
        gear = (s < GEAR_MASK_W && gear_mask[s]) ? GEAR_HIGH : GEAR_LOW;
        q = (x * 45) / (4 * gear);
        r.hit = 1'b1;
        r.slot = SLOT_W'(s);
        r.turns = turn_count[s];
        r.shaft_angle_q8 = q[SHAFT_W-1:0];
        return r;
    endfunction

    task automatic log_error(input string msg);
        n_errors++;
        $display("ERROR: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
        if (got !== want)
            log_error($sformatf("report beat %0d: %s is %0d, predicted %0d",
                                n_out, name, got, want));
    endtask

    task automatic enqueue_frame(input logic [ACTION_W-1:0] act, input logic b,
                                 input logic [CAN_ID_W-1:0] id,
                                 input logic [MOTOR_W-1:0] motor,
                                 input logic [15:0] ang, input logic [15:0] spd,
                                 input logic [15:0] cur);
        metf_item_t it;
        it.action = act;
        it.bus = b;
        it.can_id = id;
        it.motor_number = motor;
        {it.angle_high, it.angle_low} = ang;
        {it.speed_high, it.speed_low} = spd;
        {it.current_high, it.current_low} = cur;
        pending_frames.push_back(it);
        n_queued++;
    endtask

    // register a slot, drive it to the base angle without counting, then spin it through a run of turns
    task automatic queue_turn_run(input logic b, input int idx, input bit count_up);
        int s;
        int a;
        int step;
        s = int'(b) * SLOTS_PER_BUS + idx;
        a = int'(prev_angle[s]);
        enqueue_frame(ACT_REGISTER, b, '0, MOTOR_W'(idx + 1), '0, '0, '0);
        while (a != int'(RUN_BASE))
        begin
            step = a - int'(RUN_BASE);
            if (step > 4096)
                step = 4096;
            else if (step < -4096)
                step = -4096;
            a = a - step;
            enqueue_frame(ACT_FEEDBACK, b, BASE_ID + CAN_ID_W'(idx), '0, 16'(a),
                          16'($urandom), 16'($urandom));
        end
        repeat (TURN_RUN)
        begin
            if (count_up)
            begin
                enqueue_frame(ACT_FEEDBACK, b, BASE_ID + CAN_ID_W'(idx), '0,
                              RUN_BASE - 16'h2000, 16'($urandom), 16'($urandom));
                enqueue_frame(ACT_FEEDBACK, b, BASE_ID + CAN_ID_W'(idx), '0,
                              RUN_BASE - 16'h1000, 16'($urandom), 16'($urandom));
            end
            else
            begin
                enqueue_frame(ACT_FEEDBACK, b, BASE_ID + CAN_ID_W'(idx), '0,
                              RUN_BASE + 16'h2000, 16'($urandom), 16'($urandom));
                enqueue_frame(ACT_FEEDBACK, b, BASE_ID + CAN_ID_W'(idx), '0,
                              RUN_BASE + 16'h1000, 16'($urandom), 16'($urandom));
            end
            enqueue_frame(ACT_FEEDBACK, b, BASE_ID + CAN_ID_W'(idx), '0, RUN_BASE,
                          16'($urandom), 16'($urandom));
        end
    endtask

    task automatic queue_random_frame();
        int pick;
        int idx;
        int s;
        int delta;
        logic b;
        logic [ANGLE_W-1:0] a;
        pick = $urandom_range(99);
        b = 1'($urandom_range(1));
        idx = $urandom_range(SLOTS_PER_BUS - 1);
        s = int'(b) * SLOTS_PER_BUS + idx;
        if (pick < 78)
        begin
            if ($urandom_range(9) < 8)
            begin
                delta = int'($urandom_range(12000)) - 6000;
                a = walk_angle[s] + 16'(delta);
            end
            else
                a = 16'($urandom);
            walk_angle[s] = a;
            enqueue_frame(ACT_FEEDBACK, b, BASE_ID + CAN_ID_W'(idx), 4'($urandom), a,
                          16'($urandom), 16'($urandom));
        end
        else if (pick < 88)
            enqueue_frame(ACT_REGISTER, b, 11'($urandom), MOTOR_W'(idx + 1),
                          16'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 93)
            enqueue_frame(ACT_CLEAR, b, 11'($urandom), MOTOR_W'(idx + 1),
                          16'($urandom), 16'($urandom), 16'($urandom));
        else
            enqueue_frame(2'($urandom), b, 11'($urandom), 4'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic settle();
        while (n_in != n_queued || reports_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_gear_mask(input logic [GEAR_MASK_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        gear_mask = v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin : drive_frames
        metf_item_t nxt;
        if (!rst_n)
            frame_bus.valid <= 1'b0;
        else if (!frame_bus.valid || beat_in)
        begin
            if (pending_frames.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                nxt = pending_frames.pop_front();
                frame_bus.valid <= 1'b1;
                frame_bus.action <= nxt.action;
                frame_bus.bus <= nxt.bus;
                frame_bus.can_id <= nxt.can_id;
                frame_bus.motor_number <= nxt.motor_number;
                frame_bus.angle_high <= nxt.angle_high;
                frame_bus.angle_low <= nxt.angle_low;
                frame_bus.speed_high <= nxt.speed_high;
                frame_bus.speed_low <= nxt.speed_low;
                frame_bus.current_high <= nxt.current_high;
                frame_bus.current_low <= nxt.current_low;
            end
            else
                frame_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        report_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin : track_beats
        tracker_report_t want;
        metf_item_t it;
        logic took_frame;
        logic took_report;
        tick++;
        took_frame = frame_bus.valid && frame_bus.ready;
        took_report = report_bus.valid && report_bus.ready;
        if (!rst_n)
            beat_in <= 1'b0;
        else
        begin
            if (took_report)
            begin
                if (reports_due.size() == 0)
                    log_error($sformatf("report beat %0d arrived with nothing due", n_out));
                else
                begin
                    want = reports_due.pop_front();
                    compare_field("hit", report_bus.hit, want.hit);
                    compare_field("slot", report_bus.slot, want.slot);
                    compare_field("turns", report_bus.turns, want.turns);
                    compare_field("shaft_angle_q8", report_bus.shaft_angle_q8,
                                  want.shaft_angle_q8);
                    compare_field("speed", report_bus.speed, want.speed);
                    compare_field("current", report_bus.current, want.current);
                end
                n_out++;
            end
            if (took_frame)
            begin
                it.action = frame_bus.action;
                it.bus = frame_bus.bus;
                it.can_id = frame_bus.can_id;
                it.motor_number = frame_bus.motor_number;
                it.angle_high = frame_bus.angle_high;
                it.angle_low = frame_bus.angle_low;
                it.speed_high = frame_bus.speed_high;
                it.speed_low = frame_bus.speed_low;
                it.current_high = frame_bus.current_high;
                it.current_low = frame_bus.current_low;
                reports_due.push_back(track_frame(it));
                n_in++;
            end
            beat_in <= took_frame;
            if (took_frame || took_report)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
                $display("multiturn_encoder_feedback_tracker_top test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [GEAR_MASK_W-1:0] m;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        frame_bus.valid = 1'b0;
        frame_bus.action = ACT_FEEDBACK;
        frame_bus.bus = 1'b0;
        frame_bus.can_id = '0;
        frame_bus.motor_number = '0;
        frame_bus.angle_high = '0;
        frame_bus.angle_low = '0;
        frame_bus.speed_high = '0;
        frame_bus.speed_low = '0;
        frame_bus.current_high = '0;
        frame_bus.current_low = '0;
        report_bus.ready = 1'b0;
        gear_mask = '0;
        n_queued = 0;
        n_in = 0;
        n_out = 0;
        n_errors = 0;
        tick = 0;
        quiet_cycles = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_live[i] = 1'b0;
            prev_angle[i] = '0;
            turn_count[i] = '0;
            angle_offset[i] = '0;
            walk_angle[i] = '0;
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // unregistered slot: feedback and clear are dropped
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h1234, 16'h1111, 16'h2222);
        enqueue_frame(ACT_CLEAR, 1'b0, 11'd0, 4'd1, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_REGISTER, 1'b0, 11'd0, 4'd1, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'hFFFF, 16'h7FFF, 16'h8000);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h0000, 16'h8000, 16'h7FFF);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h1000, 16'h0001, 16'hFFFF);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h1001, 16'hFFFF, 16'h0001);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h0000, 16'h00FF, 16'hFF00);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h8000, 16'hFF00, 16'h00FF);
        // re-register latches the latest angle as offset
        enqueue_frame(ACT_REGISTER, 1'b0, 11'd0, 4'd1, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_REGISTER, 1'b1, 11'd0, 4'd8, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_FEEDBACK, 1'b1, BASE_ID + 11'd7, 4'd0, 16'hFFFF, 16'hFFFF, 16'h0);
        enqueue_frame(ACT_CLEAR, 1'b1, 11'd0, 4'd8, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_UNKNOWN, 1'b1, 11'h7FF, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        enqueue_frame(ACT_FEEDBACK, 1'b0, 11'h200, 4'd0, 16'h4000, 16'h1, 16'h1);
        enqueue_frame(ACT_FEEDBACK, 1'b0, 11'h209, 4'd0, 16'h4000, 16'h1, 16'h1);
        enqueue_frame(ACT_FEEDBACK, 1'b0, 11'h000, 4'd0, 16'h4000, 16'h1, 16'h1);
        enqueue_frame(ACT_FEEDBACK, 1'b1, 11'h7FF, 4'd0, 16'h4000, 16'h1, 16'h1);
        enqueue_frame(ACT_REGISTER, 1'b0, 11'd0, 4'd0, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_REGISTER, 1'b0, 11'd0, 4'd9, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_CLEAR, 1'b1, 11'd0, 4'd15, 16'h0, 16'h0, 16'h0);
        enqueue_frame(ACT_FEEDBACK, 1'b0, BASE_ID, 4'd0, 16'h0000, 16'h5A5A, 16'hA5A5);
        enqueue_frame(ACT_CLEAR, 1'b0, 11'd0, 4'd1, 16'h0, 16'h0, 16'h0);
        settle();

        queue_turn_run(1'b0, 0, 1'b0);
        repeat (RANDOM_PER_PHASE) queue_random_frame();
        settle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: m = 16'hFFFF;
                1: m = 16'hA5A5;
                2: m = 16'($urandom);
                default: m = 16'h0000;
            endcase
            set_gear_mask(m);
            if (ph == 0)
                queue_turn_run(1'b1, SLOTS_PER_BUS - 1, 1'b1);
            repeat (RANDOM_PER_PHASE) queue_random_frame();
            settle();
        end

        $display("Covered %0d frame beats and %0d report beats over five gear mask settings,",
                 n_in, n_out);
        $display("with turn runs counted in both directions; %0d mismatches.", n_errors);
        if (n_errors == 0)
            $display("multiturn_encoder_feedback_tracker_top test passed");
        else
            $display("multiturn_encoder_feedback_tracker_top test failed");
        $finish;
    end

endmodule
